### sv/ffba_pkg.sv
// Package of the first-fit block allocator: operation and status codes,
// sequencer states, field widths and the result record.
// Depends on nothing; ffba_match and the top level import it.
package ffba_pkg;

	// Widths of the transaction fields, fixed by the interface.
	localparam int unsigned REQ_W    = 10;
	localparam int unsigned ADDR_W   = 10;
	localparam int unsigned OFS_W    = 10;
	localparam int unsigned STATUS_W = 2;
	// A block size is a request plus a header.
	localparam int unsigned NEED_W   = 11;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_OOM      = 2'd1,
		STATUS_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

	typedef struct packed {
		status_t           status;
		logic [OFS_W-1:0]  payload_offset;
		logic              was_reused;
	} result_t;

endpackage

### sv/ffba_table.sv
// Block table memory of the allocator: one write port and one read port,
// with the read data registered.
// Depends on nothing outside this file.
module ffba_table #(
	parameter int unsigned DW    = 27,
	parameter int unsigned DEPTH = 128,
	parameter int unsigned IW    = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/ffba_match.sv
// Shared compare unit of the allocator: decides whether one table entry
// satisfies the current request. Imports ffba_pkg for codes and widths.
module ffba_match #(
	parameter int unsigned OW           = 10,
	parameter int unsigned HEADER_BYTES = 8
) (
	input  ffba_pkg::op_t                    op,
	input  logic [ffba_pkg::NEED_W-1:0]      need,
	input  logic [ffba_pkg::ADDR_W-1:0]      free_address,
	input  logic [OW-1:0]                    blk_start,
	input  logic [ffba_pkg::NEED_W-1:0]      blk_size,
	input  logic                             blk_free,
	output logic                             hit
);
	import ffba_pkg::*;

	// Width that holds a block start plus the header and a payload address.
	localparam int unsigned MW = (OW + 1 > ADDR_W) ? OW + 1 : ADDR_W;

	logic [MW-1:0] payload_addr;

	assign payload_addr = MW'(blk_start) + MW'(HEADER_BYTES);

	// Allocate wants a free block that is large enough; free wants the block
	// whose payload starts at the address handed back.
	always_comb begin
		case (op)
			OP_ALLOC: hit = blk_free && (blk_size >= need);
			OP_FREE:  hit = (payload_addr == MW'(free_address));
			default:  hit = 1'b0;
		endcase
	end

endmodule

### sv/first_fit_block_allocator_top.sv
// First-fit block allocator, top level. Each transaction walks the table entries below
// the block count in order, one entry per cycle, through the single table read port and
// the compare unit, and stops at the first entry that matches. If none matches, an
// allocate is appended after the last block or refused as out of memory, and a free
// is refused as a bad free. A new transaction is taken only in the idle state.
// Reset clears the block count, end pointer and handshake state, not the table.
module first_fit_block_allocator_top #(
	parameter int unsigned CAPACITY     = 1024,
	parameter int unsigned HEADER_BYTES = 8,
	parameter int unsigned MAX_BLOCKS   = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [9:0] request_bytes, [19:10] free_address, rest zero
	input  logic        s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [9:0] payload_offset, [10] was_reused, rest zero
	output logic [1:0]  m_tuser    // [1:0] status
);
	import ffba_pkg::*;

	localparam int unsigned OW = $clog2(CAPACITY);
	localparam int unsigned IW = $clog2(MAX_BLOCKS);
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned EW = OW + NEED_W + 1;
	localparam int unsigned SW = ((OW > NEED_W) ? OW : NEED_W) + 1;
	localparam int unsigned MW = (OW + 1 > OFS_W) ? OW + 1 : OFS_W;

	state_t state_q, state_d;

	op_t                op_q;
	logic [NEED_W-1:0]  need_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [CW-1:0]      rd_idx_q;
	logic               vld_s1;
	logic [IW-1:0]      idx_s1;
	logic [CW-1:0]      count_q;
	logic [OW-1:0]      end_q;
	result_t            res_q, res_d;
	logic               m_valid_q;

	logic               issue;
	logic               hit;
	logic               match_hit;
	logic               scan_end;
	logic               finish;
	logic               out_load;
	logic               do_append;
	logic [SW-1:0]      new_end;
	logic [MW-1:0]      hit_payload;
	logic [MW-1:0]      app_payload;

	logic               tbl_we;
	logic [IW-1:0]      tbl_waddr;
	logic [EW-1:0]      tbl_wdata;
	logic [EW-1:0]      tbl_rdata;
	logic [OW-1:0]      rd_start;
	logic [NEED_W-1:0]  rd_size;
	logic               rd_free;

	// Handshake and scan control.
	assign s_tready = (state_q == ST_IDLE);
	assign issue    = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign hit      = (state_q == ST_SCAN) && vld_s1 && match_hit;
	assign scan_end = (state_q == ST_SCAN) && !vld_s1 && !issue;
	assign finish   = hit || scan_end;
	assign out_load = (state_q == ST_RESP) && (!m_valid_q || m_tready);

	// Table entry fields, lowest bits first: start, size, free flag.
	assign rd_start = tbl_rdata[OW-1:0];
	assign rd_size  = tbl_rdata[OW +: NEED_W];
	assign rd_free  = tbl_rdata[EW-1];

	ffba_table #(
		.DW    (EW),
		.DEPTH (MAX_BLOCKS),
		.IW    (IW)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (issue),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (tbl_rdata)
	);

	ffba_match #(
		.OW           (OW),
		.HEADER_BYTES (HEADER_BYTES)
	) u_match (
		.op           (op_q),
		.need         (need_q),
		.free_address (addr_q),
		.blk_start    (rd_start),
		.blk_size     (rd_size),
		.blk_free     (rd_free),
		.hit          (match_hit)
	);

	// Append arithmetic and the payload offset of a reused block.
	assign new_end     = SW'(end_q) + SW'(need_q);
	assign hit_payload = MW'(rd_start) + MW'(HEADER_BYTES);
	assign app_payload = MW'(end_q) + MW'(HEADER_BYTES);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (finish) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Table updates and the result of the transaction.
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = idx_s1;
		tbl_wdata = {(op_q == OP_FREE), rd_size, rd_start};
		do_append = 1'b0;
		res_d     = '{status: STATUS_OK, payload_offset: '0, was_reused: 1'b0};
		if (hit) begin
			tbl_we = 1'b1;
			if (op_q == OP_ALLOC) begin
				res_d.payload_offset = hit_payload[OFS_W-1:0];
				res_d.was_reused     = 1'b1;
			end
		end else if (scan_end) begin
			if (op_q == OP_FREE) begin
				res_d.status = STATUS_BAD_FREE;
			end else if (new_end >= SW'(CAPACITY - 1) || count_q >= CW'(MAX_BLOCKS)) begin
				res_d.status = STATUS_OOM;
			end else begin
				do_append            = 1'b1;
				tbl_we               = 1'b1;
				tbl_waddr            = count_q[IW-1:0];
				tbl_wdata            = {1'b0, need_q, end_q};
				res_d.payload_offset = app_payload[OFS_W-1:0];
			end
		end
	end

	// Sequencer and heap state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			end_q     <= '0;
			vld_s1    <= 1'b0;
			rd_idx_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_tvalid && s_tready) begin
				rd_idx_q <= '0;
				vld_s1   <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
			end
			if (do_append) begin
				count_q <= count_q + CW'(1);
				end_q   <= new_end[OW-1:0];
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Captured request, scan index and result payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= op_t'(s_tuser);
			need_q <= NEED_W'(s_tdata[REQ_W-1:0]) + NEED_W'(HEADER_BYTES);
			addr_q <= s_tdata[REQ_W +: ADDR_W];
		end
		idx_s1 <= rd_idx_q[IW-1:0];
		if (finish) begin
			res_q <= res_d;
		end
	end

	// Output register.
	result_t out_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {5'b0, out_q.was_reused, out_q.payload_offset};

endmodule
